>>> design/dpbd_pkg.sv
// ----------------------------------------------------------------------------
// dpbd_pkg
// Shared types and constants of the disk pulse bit deframer: event codes,
// configuration register indexes, reset values and the item and flag structs.
// ----------------------------------------------------------------------------
package dpbd_pkg;

    // Event codes carried in the operation field.
    typedef enum logic [1:0] {
        OP_EDGE    = 2'd0,
        OP_RESTART = 2'd1,
        OP_READY   = 2'd2
    } t_op;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_COUNT    = 1'd1;

    // Register and state reset values.
    localparam logic [7:0]  THRESHOLD_RESET = 8'h21;
    localparam logic [15:0] SKIP_RESET      = 16'd14000;

    // Fixed widths of the result fields.
    localparam int unsigned POS_OUT_W = 8;
    localparam int unsigned CNT_OUT_W = 32;

    // Parameter defaults.
    localparam int unsigned BUFFER_BYTES_DEF = 256;
    localparam int unsigned COUNT_WIDTH_DEF  = 32;

    // One input item as it travels from the input register to the update logic.
    typedef struct packed {
        t_op        operation;
        logic [7:0] interval;
        logic       ready_level;
    } t_item;

    // Per-item status flags of a result.
    typedef struct packed {
        logic byte_valid;
        logic buffer_full;
        logic sync_found;
    } t_flags;

endpackage

>>> design/disk_pulse_bit_deframer_core.sv
// ----------------------------------------------------------------------------
// disk_pulse_bit_deframer_core
// Turns read-data edge timing events into bytes framed by a gap start mark.
// ----------------------------------------------------------------------------
// The block accepts one event per clock cycle while the output is not stalled
// and returns exactly one result transfer per event. An event passes through
// an input register, then a single update step (threshold compare, skip
// countdown, gap search, byte shift and buffer bookkeeping) writes both the
// deframer state and the result register on the same edge, so back-to-back
// edge events see each other's state without bubbles. Each side has its own
// register, so a new event is taken while a finished result still waits
// downstream; the input stalls only when both registers are full and the
// output is stalled. Edge events are ignored while the drive is not ready.
// After a restart event, the first skip_count decoded bits only advance the
// bit total; the first one bit after that ends the gap, if still open from
// reset, and latches the bit total as the gap length. Bytes are assembled
// most significant bit first and tagged with their position in the active
// ping-pong buffer; the byte that fills a buffer of BUFFER_BYTES entries sets
// buffer_full and switches buffers. The bit total and gap counters are
// COUNT_WIDTH bits wide and wrap; results show their low 32 bits. The
// configuration registers may be written only while no event is in flight.
// ----------------------------------------------------------------------------
module disk_pulse_bit_deframer_core #(
    parameter int unsigned BUFFER_BYTES = dpbd_pkg::BUFFER_BYTES_DEF,
    parameter int unsigned COUNT_WIDTH  = dpbd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_wr_en,
    input  logic [dpbd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dpbd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Event input channel.
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_operation,
    input  logic [7:0]                        i_interval,
    input  logic                              i_ready_level,
    // Result output channel.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_byte_valid,
    output logic [7:0]                        o_data_byte,
    output logic [dpbd_pkg::POS_OUT_W-1:0]    o_byte_position,
    output logic                              o_buffer_select,
    output logic                              o_buffer_full,
    output logic                              o_sync_found,
    output logic [dpbd_pkg::CNT_OUT_W-1:0]    o_gap_length,
    output logic [dpbd_pkg::CNT_OUT_W-1:0]    o_total_bits
);
    import dpbd_pkg::*;

    localparam int unsigned POS_W = $clog2(BUFFER_BYTES);

    // Configuration registers.
    logic [7:0]  r_threshold;
    logic [15:0] r_skip_count;

    // Deframer state.
    logic                   r_ready;
    logic [15:0]            r_skip_left;
    logic                   r_in_gap;
    logic [7:0]             r_shift;
    logic [2:0]             r_bit_index;
    logic [POS_W-1:0]       r_wpos;
    logic                   r_buffer;
    logic [COUNT_WIDTH-1:0] r_total;
    logic [COUNT_WIDTH-1:0] r_gap_bits;

    logic                   n_ready;
    logic [15:0]            n_skip_left;
    logic                   n_in_gap;
    logic [7:0]             n_shift;
    logic [2:0]             n_bit_index;
    logic [POS_W-1:0]       n_wpos;
    logic                   n_buffer;
    logic [COUNT_WIDTH-1:0] n_total;
    logic [COUNT_WIDTH-1:0] n_gap_bits;

    // Result register.
    logic                   r_out_valid;
    t_flags                 r_flags;
    logic [7:0]             r_data_byte;
    logic [POS_OUT_W-1:0]   r_byte_position;
    logic                   r_buffer_select;
    logic [CNT_OUT_W-1:0]   r_gap_length;
    logic [CNT_OUT_W-1:0]   r_total_bits;

    t_flags                 n_flags;
    logic [7:0]             n_data_byte;
    logic [POS_OUT_W-1:0]   n_byte_position;
    logic                   n_buffer_select;
    logic [CNT_OUT_W-1:0]   n_gap_length;
    logic [CNT_OUT_W-1:0]   n_total_bits;

    // Input stage interface.
    t_item in_item;
    t_item held_item;
    logic  held_valid;
    logic  advance;
    logic  step_fire;

    assign in_item.operation   = t_op'(i_operation);
    assign in_item.interval    = i_interval;
    assign in_item.ready_level = i_ready_level;

    // The result register can take a new result when it is empty or its
    // current result is being transferred out in this cycle.
    assign advance   = ~r_out_valid | ~i_out_stall;
    assign step_fire = held_valid & advance;

    dpbd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_stall   (o_in_stall),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    dpbd_step #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .POS_W       (POS_W),
        .POS_LAST    (BUFFER_BYTES - 1)
    ) u_step (
        .i_item          (held_item),
        .i_threshold     (r_threshold),
        .i_skip_count    (r_skip_count),
        .i_ready         (r_ready),
        .i_skip_left     (r_skip_left),
        .i_in_gap        (r_in_gap),
        .i_shift         (r_shift),
        .i_bit_index     (r_bit_index),
        .i_wpos          (r_wpos),
        .i_buffer        (r_buffer),
        .i_total         (r_total),
        .i_gap_bits      (r_gap_bits),
        .o_ready         (n_ready),
        .o_skip_left     (n_skip_left),
        .o_in_gap        (n_in_gap),
        .o_shift         (n_shift),
        .o_bit_index     (n_bit_index),
        .o_wpos          (n_wpos),
        .o_buffer        (n_buffer),
        .o_total         (n_total),
        .o_gap_bits      (n_gap_bits),
        .o_flags         (n_flags),
        .o_data_byte     (n_data_byte),
        .o_byte_position (n_byte_position),
        .o_buffer_select (n_buffer_select),
        .o_gap_length    (n_gap_length),
        .o_total_bits    (n_total_bits)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THRESHOLD_RESET;
            r_skip_count <= SKIP_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_BIT_THRESHOLD: r_threshold  <= i_cfg_data[7:0];
                CFG_SKIP_COUNT:    r_skip_count <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // State is committed when the held event moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready     <= 1'b0;
            r_skip_left <= SKIP_RESET;
            r_in_gap    <= 1'b1;
            r_shift     <= '0;
            r_bit_index <= '0;
            r_wpos      <= '0;
            r_buffer    <= 1'b0;
            r_total     <= '0;
            r_gap_bits  <= '0;
        end else if (step_fire) begin
            r_ready     <= n_ready;
            r_skip_left <= n_skip_left;
            r_in_gap    <= n_in_gap;
            r_shift     <= n_shift;
            r_bit_index <= n_bit_index;
            r_wpos      <= n_wpos;
            r_buffer    <= n_buffer;
            r_total     <= n_total;
            r_gap_bits  <= n_gap_bits;
        end
    end

    // Result register valid: loaded by each committed event, cleared when
    // the result is transferred without a new one behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= held_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_flags         <= n_flags;
            r_data_byte     <= n_data_byte;
            r_byte_position <= n_byte_position;
            r_buffer_select <= n_buffer_select;
            r_gap_length    <= n_gap_length;
            r_total_bits    <= n_total_bits;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_byte_valid    = r_flags.byte_valid;
    assign o_buffer_full   = r_flags.buffer_full;
    assign o_sync_found    = r_flags.sync_found;
    assign o_data_byte     = r_data_byte;
    assign o_byte_position = r_byte_position;
    assign o_buffer_select = r_buffer_select;
    assign o_gap_length    = r_gap_length;
    assign o_total_bits    = r_total_bits;

endmodule

>>> design/dpbd_in_stage.sv
// ----------------------------------------------------------------------------
// dpbd_in_stage
// Input register of the deframer. Holds one item and stalls the upstream
// side only while that item cannot move on to the update stage.
// ----------------------------------------------------------------------------
module dpbd_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  dpbd_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_stall,
    output logic           o_valid,
    output dpbd_pkg::t_item o_item
);
    import dpbd_pkg::*;

    logic  r_valid;
    t_item r_item;

    // The held item leaves when the next stage can take it.
    assign o_stall = r_valid & ~i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

endmodule

>>> design/dpbd_step.sv
// ----------------------------------------------------------------------------
// dpbd_step
// Update logic for one item: bit decision, skip countdown, gap search,
// byte assembly and ping-pong buffer bookkeeping, plus the result fields.
// ----------------------------------------------------------------------------
module dpbd_step #(
    parameter int unsigned COUNT_WIDTH = dpbd_pkg::COUNT_WIDTH_DEF,
    parameter int unsigned POS_W       = 8,
    parameter int unsigned POS_LAST    = 255
) (
    input  dpbd_pkg::t_item         i_item,
    input  logic [7:0]              i_threshold,
    input  logic [15:0]             i_skip_count,
    // Current state.
    input  logic                    i_ready,
    input  logic [15:0]             i_skip_left,
    input  logic                    i_in_gap,
    input  logic [7:0]              i_shift,
    input  logic [2:0]              i_bit_index,
    input  logic [POS_W-1:0]        i_wpos,
    input  logic                    i_buffer,
    input  logic [COUNT_WIDTH-1:0]  i_total,
    input  logic [COUNT_WIDTH-1:0]  i_gap_bits,
    // Next state.
    output logic                    o_ready,
    output logic [15:0]             o_skip_left,
    output logic                    o_in_gap,
    output logic [7:0]              o_shift,
    output logic [2:0]              o_bit_index,
    output logic [POS_W-1:0]        o_wpos,
    output logic                    o_buffer,
    output logic [COUNT_WIDTH-1:0]  o_total,
    output logic [COUNT_WIDTH-1:0]  o_gap_bits,
    // Result fields.
    output dpbd_pkg::t_flags        o_flags,
    output logic [7:0]              o_data_byte,
    output logic [dpbd_pkg::POS_OUT_W-1:0] o_byte_position,
    output logic                    o_buffer_select,
    output logic [dpbd_pkg::CNT_OUT_W-1:0] o_gap_length,
    output logic [dpbd_pkg::CNT_OUT_W-1:0] o_total_bits
);
    import dpbd_pkg::*;

    logic             data_bit;
    logic [7:0]       shift_next;
    logic [POS_W-1:0] byte_pos;

    assign data_bit   = (i_item.interval >= i_threshold);
    assign shift_next = {i_shift[6:0], data_bit};

    always_comb begin
        o_ready         = i_ready;
        o_skip_left     = i_skip_left;
        o_in_gap        = i_in_gap;
        o_shift         = i_shift;
        o_bit_index     = i_bit_index;
        o_wpos          = i_wpos;
        o_buffer        = i_buffer;
        o_total         = i_total;
        o_gap_bits      = i_gap_bits;
        o_flags         = '0;
        o_data_byte     = '0;
        byte_pos        = '0;
        o_buffer_select = 1'b0;

        case (i_item.operation)
            OP_RESTART: begin
                o_skip_left = i_skip_count;
            end
            OP_READY: begin
                o_ready = i_item.ready_level;
            end
            OP_EDGE: begin
                if (i_ready) begin
                    if (i_skip_left != 16'd0) begin
                        o_skip_left = i_skip_left - 16'd1;
                    end else if (i_in_gap) begin
                        if (data_bit) begin
                            o_gap_bits         = i_total;
                            o_in_gap           = 1'b0;
                            o_flags.sync_found = 1'b1;
                        end
                    end else begin
                        o_shift     = shift_next;
                        // Three bits wrap to zero after the eighth bit.
                        o_bit_index = i_bit_index + 3'd1;
                        if (i_bit_index == 3'd7) begin
                            o_flags.byte_valid = 1'b1;
                            o_data_byte        = shift_next;
                            byte_pos           = i_wpos;
                            o_buffer_select    = i_buffer;
                            if (i_wpos == POS_W'(POS_LAST)) begin
                                o_wpos              = '0;
                                o_flags.buffer_full = 1'b1;
                                o_buffer            = ~i_buffer;
                            end else begin
                                o_wpos = i_wpos + POS_W'(1);
                            end
                        end
                    end
                    o_total = i_total + COUNT_WIDTH'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Fit the position and the counters to the fixed result widths.
    generate
        if (POS_W >= POS_OUT_W) begin : g_pos_trunc
            assign o_byte_position = byte_pos[POS_OUT_W-1:0];
        end else begin : g_pos_ext
            assign o_byte_position = {{(POS_OUT_W-POS_W){1'b0}}, byte_pos};
        end
        if (COUNT_WIDTH >= CNT_OUT_W) begin : g_cnt_trunc
            assign o_gap_length = o_gap_bits[CNT_OUT_W-1:0];
            assign o_total_bits = o_total[CNT_OUT_W-1:0];
        end else begin : g_cnt_ext
            assign o_gap_length = {{(CNT_OUT_W-COUNT_WIDTH){1'b0}}, o_gap_bits};
            assign o_total_bits = {{(CNT_OUT_W-COUNT_WIDTH){1'b0}}, o_total};
        end
    endgenerate

endmodule
